### src/frlq_pkg.sv
// Package with the item types and fixed constants of the fetch request latency queue.
`timescale 1ns / 1ps

package frlq_pkg;

  // Width of the opaque predictor checkpoint tag carried with each request.
  localparam int TAG_WIDTH = 16;

  // Instruction word that marks the end of the program.
  localparam logic [31:0] HALT_WORD = 32'h0ff00513;

  // Width of the reported occupancy.
  localparam int OCC_WIDTH = 4;

  // One input item: the fetch stage's view of one processor cycle.
  typedef struct packed {
    logic                 squash;
    logic [31:0]          squash_target;
    logic                 fetch_valid;
    logic [31:0]          fetch_addr;
    logic [31:0]          predicted_next;
    logic [TAG_WIDTH-1:0] predictor_tag;
    logic                 downstream_full;
    logic [31:0]          memory_word;
  } request_t;

  // One result item.
  typedef struct packed {
    logic                 deliver_valid;
    logic [31:0]          deliver_addr;
    logic [31:0]          deliver_predicted;
    logic [31:0]          deliver_word;
    logic [TAG_WIDTH-1:0] deliver_tag;
    logic                 read_valid;
    logic [31:0]          read_addr;
    logic [31:0]          next_fetch_pc;
    logic                 halt_seen;
    logic [OCC_WIDTH-1:0] occupancy;
    logic                 overflow;
  } result_t;

  // Per-slot request data written when a request is queued.
  typedef struct packed {
    logic [31:0]          addr;
    logic [31:0]          predicted;
    logic [TAG_WIDTH-1:0] tag;
  } slot_meta_t;

endpackage

### src/frlq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module frlq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/frlq_pipe.sv
// Delay line that tracks requests in flight until their memory word arrives.
`timescale 1ns / 1ps

module frlq_pipe #(
  parameter int LATENCY = 3,
  parameter int IW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          flush,
  input  logic          push_valid,
  input  logic [IW-1:0] push_slot,
  input  logic [31:0]   push_addr,
  output logic          out_valid,
  output logic [IW-1:0] out_slot,
  output logic [31:0]   out_addr
);

  logic          stage_valid [LATENCY];
  logic [IW-1:0] stage_slot [LATENCY];
  logic [31:0]   stage_addr [LATENCY];

  // Valid bits: cleared by reset and by a squash, shifted once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LATENCY; i++) begin
        stage_valid[i] <= 1'b0;
      end
    end else if (advance) begin
      if (flush) begin
        for (int i = 0; i < LATENCY; i++) begin
          stage_valid[i] <= 1'b0;
        end
      end else begin
        stage_valid[0] <= push_valid;
        for (int i = 1; i < LATENCY; i++) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // Slot index and PC travel alongside the valid bit.
  always_ff @(posedge clk) begin
    if (advance && !flush) begin
      stage_slot[0] <= push_slot;
      stage_addr[0] <= push_addr;
      for (int i = 1; i < LATENCY; i++) begin
        stage_slot[i] <= stage_slot[i-1];
        stage_addr[i] <= stage_addr[i-1];
      end
    end
  end

  // The last stage holds the request whose countdown ends in the current item.
  assign out_valid = stage_valid[LATENCY-1];
  assign out_slot  = stage_slot[LATENCY-1];
  assign out_addr  = stage_addr[LATENCY-1];

endmodule

### src/fetch_request_latency_queue.sv
// Top level of the fixed-latency instruction fetch request queue.
`timescale 1ns / 1ps

// The block takes one item in every clock cycle: busy is never raised, so start
// may be held high continuously. Each accepted item is captured in an input
// register and processed against the queue state in the following cycle. Its
// result is registered at the end of that cycle and is on the result port with
// done high for one cycle. The receiver cannot stall; none is needed. Slot
// data lives in two small RAMs read at the next head slot every cycle, and a
// short delay line of FETCH_LATENCY stages marks the request whose word
// arrives.
module fetch_request_latency_queue #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int FETCH_LATENCY = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  frlq_pkg::request_t request,
  output logic               done,
  output frlq_pkg::result_t  result
);

  import frlq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = $bits(slot_meta_t);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_W   = (IW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

  // Input register.
  logic     in_valid;
  request_t in_item;

  // Queue state.
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ready_cnt, ready_cnt_next;
  logic [31:0]   fetch_pc, fetch_pc_next;
  logic          halt, halt_next;

  // Forwarding of a word written to the slot being read in the same cycle.
  logic          byp_valid, byp_valid_next;
  logic [31:0]   byp_word;

  result_t       res_next;

  // Working signals.
  logic          sq, proc, head_rdy, remove, deliver, push, capture;
  logic [IW-1:0] head_inc, head_a, push_slot;
  logic [CW-1:0] count_a;
  logic [IW:0]   slot_sum;
  logic [31:0]   head_word;
  slot_meta_t    meta_w, meta_q;
  logic [31:0]   word_q;
  logic          pipe_valid;
  logic [IW-1:0] pipe_slot;
  logic [31:0]   pipe_addr;

  assign busy = 1'b0;

  // Input register: an item is taken whenever start is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_item <= request;
    end
  end

  // Head removal and push slot.
  always_comb begin
    sq        = in_valid && in_item.squash;
    proc      = in_valid && !in_item.squash;
    head_rdy  = (ready_cnt != '0);
    remove    = proc && head_rdy && (halt || !in_item.downstream_full);
    deliver   = proc && head_rdy && !halt && !in_item.downstream_full;
    head_word = byp_valid ? byp_word : word_q;
    head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
    head_a    = remove ? head_inc : head;
    count_a   = count - CW'(remove);
    push      = proc && in_item.fetch_valid && (count_a != DEPTH_C);
    capture   = proc && pipe_valid;
    slot_sum  = (IW + 1)'(head_a) + (IW + 1)'(count_a);
    push_slot = (slot_sum >= DEPTH_W) ? IW'(slot_sum - DEPTH_W) : IW'(slot_sum);
  end

  // Next state of the queue.
  always_comb begin
    head_next      = head;
    count_next     = count;
    ready_cnt_next = ready_cnt;
    fetch_pc_next  = fetch_pc;
    halt_next      = halt;
    if (sq) begin
      head_next      = '0;
      count_next     = '0;
      ready_cnt_next = '0;
      fetch_pc_next  = in_item.squash_target;
      halt_next      = 1'b0;
    end else if (proc) begin
      head_next      = head_a;
      count_next     = count_a + CW'(push);
      ready_cnt_next = ready_cnt - CW'(remove) + CW'(capture);
      fetch_pc_next  = push ? in_item.predicted_next : fetch_pc;
      halt_next      = halt || (deliver && head_word == HALT_WORD);
    end
    byp_valid_next = capture && (pipe_slot == head_next);
  end

  // Result of the processed item.
  always_comb begin
    res_next                   = '0;
    res_next.deliver_valid     = deliver;
    if (deliver) begin
      res_next.deliver_addr      = meta_q.addr;
      res_next.deliver_predicted = meta_q.predicted;
      res_next.deliver_word      = head_word;
      res_next.deliver_tag       = meta_q.tag;
    end
    res_next.read_valid        = capture;
    res_next.read_addr         = capture ? pipe_addr : '0;
    res_next.next_fetch_pc     = fetch_pc_next;
    res_next.halt_seen         = halt_next;
    res_next.occupancy         = OCC_WIDTH'(count_next);
    res_next.overflow          = proc && in_item.fetch_valid && !push;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      ready_cnt <= '0;
      fetch_pc  <= '0;
      halt      <= 1'b0;
      byp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      ready_cnt <= ready_cnt_next;
      fetch_pc  <= fetch_pc_next;
      halt      <= halt_next;
      byp_valid <= byp_valid_next;
      done      <= in_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byp_word <= in_item.memory_word;
    if (in_valid) begin
      result <= res_next;
    end
  end

  // Request data written at push time.
  assign meta_w.addr      = in_item.fetch_addr;
  assign meta_w.predicted = in_item.predicted_next;
  assign meta_w.tag       = in_item.predictor_tag;

  frlq_ram #(
    .WIDTH(MW),
    .DEPTH(QUEUE_DEPTH)
  ) u_meta_ram (
    .clk  (clk),
    .we   (push),
    .waddr(push_slot),
    .wdata(meta_w),
    .raddr(head_next),
    .rdata(meta_q)
  );

  // Instruction words written when a request's countdown ends.
  frlq_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH)
  ) u_word_ram (
    .clk  (clk),
    .we   (capture),
    .waddr(pipe_slot),
    .wdata(in_item.memory_word),
    .raddr(head_next),
    .rdata(word_q)
  );

  // Countdown of requests in flight.
  frlq_pipe #(
    .LATENCY(FETCH_LATENCY),
    .IW     (IW)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_valid),
    .flush     (in_item.squash),
    .push_valid(push),
    .push_slot (push_slot),
    .push_addr (in_item.fetch_addr),
    .out_valid (pipe_valid),
    .out_slot  (pipe_slot),
    .out_addr  (pipe_addr)
  );

endmodule

### src/frlq_checker.sv
// Port-level checker for the fetch request latency queue, bound to the top level.
`timescale 1ns / 1ps

module frlq_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input frlq_pkg::request_t request,
  input logic               done,
  input frlq_pkg::result_t  result
);

  import frlq_pkg::*;

  // Every accepted item yields its result once it has passed the input register and been processed.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("accepted item produced no result");

  // A result only ever follows an accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> ##1 !done)
    else $error("result without an accepted item");

  // A squash empties the queue, clears the halt mark and redirects fetch.
  a_squash: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.squash |=> ##1
      (done && result.occupancy == '0 && !result.halt_seen &&
       !result.deliver_valid && !result.read_valid && !result.overflow &&
       result.next_fetch_pc == $past(request.squash_target, 2)))
    else $error("squash result is wrong");

  // A dropped push means the queue stayed full, so nothing left it that cycle.
  a_overflow_no_deliver: assert property (@(posedge clk) disable iff (rst)
    done && result.overflow |-> !result.deliver_valid)
    else $error("overflow reported together with a delivery");

  // Fields of an absent delivery read as zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    done && !result.deliver_valid |->
      (result.deliver_addr == '0 && result.deliver_predicted == '0 &&
       result.deliver_word == '0 && result.deliver_tag == '0))
    else $error("delivery fields not zero without a delivery");

endmodule

bind fetch_request_latency_queue frlq_checker u_frlq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);
